@@ hw/rtl/eabb_pkg.sv @@
// ============================================================================
// eabb_pkg
// Shared constants, types and arithmetic helpers for the arc bounding box.
// ============================================================================
package eabb_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int ANGLE_WIDTH_DEF = 16;

    localparam int FRAC = 30;
    localparam logic [30:0] ONE_Q     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q = 31'd1686629713;   // pi/2 in Q30

    // quadrant codes, quadrant 1 .. quadrant 4
    localparam logic [1:0] QUAD_1 = 2'd0;
    localparam logic [1:0] QUAD_2 = 2'd1;
    localparam logic [1:0] QUAD_3 = 2'd2;
    localparam logic [1:0] QUAD_4 = 2'd3;

    localparam logic [15:0] SIDE_LEFT   = 16'h1000;
    localparam logic [15:0] SIDE_BOTTOM = 16'h0100;
    localparam logic [15:0] SIDE_RIGHT  = 16'h0010;
    localparam logic [15:0] SIDE_TOP    = 16'h0001;
    localparam logic [15:0] SIDE_ALL    = 16'h1111;

    // sides taken from the ellipse itself, indexed by {start quad, end quad}
    localparam logic [15:0] SIDE_TABLE [16] = '{
        16'h0000, 16'h1011, 16'h0011, 16'h0010,
        16'h0100, 16'h0000, 16'h0111, 16'h0110,
        16'h1100, 16'h1000, 16'h0000, 16'h1110,
        16'h1101, 16'h1001, 16'h0001, 16'h0000
    };

    // Horner divisors of the sine series, as reciprocal multiply and shift;
    // exact for any 32-bit dividend
    localparam int NUM_DIV = 5;
    localparam int DIV_S [NUM_DIV] = '{39, 39, 38, 37, 35};
    localparam logic [63:0] DIV_M [NUM_DIV] = '{
        ((64'd1 << 39) + 64'd109) / 64'd110,
        ((64'd1 << 39) + 64'd71)  / 64'd72,
        ((64'd1 << 38) + 64'd41)  / 64'd42,
        ((64'd1 << 37) + 64'd19)  / 64'd20,
        ((64'd1 << 35) + 64'd5)   / 64'd6
    };

    localparam int SINE_LAT   = 2 * NUM_DIV + 2;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    typedef struct packed {
        logic [30:0] w;
        logic [31:0] w2;
        logic [31:0] acc;
    } sine_st_t;

    typedef struct packed {
        logic [62:0] n;
        logic [63:0] r;
    } sqrt_st_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] d;
        logic [30:0] q;
    } div_st_t;

    typedef struct packed {
        logic       cneg;
        logic       sneg;
        logic [1:0] quad;
    } ep_t;

    function automatic logic [31:0] div_const(input logic [31:0] x, input logic [2:0] idx);
        logic [65:0] prod;
        prod = 66'(x) * 66'(DIV_M[idx]);
        return 32'(prod >> DIV_S[idx]);
    endfunction

    // (a * b) >> FRAC, known to fit 32 bits
    function automatic logic [31:0] mul_q(input logic [31:0] a, input logic [30:0] b);
        logic [62:0] p;
        p = 63'(a) * 63'(b);
        return p[61:30];
    endfunction

endpackage

@@ hw/rtl/eabb_sine.sv @@
// ============================================================================
// eabb_sine
// Pipelined Q30 sine of a fraction of a quarter turn, Horner series to w^11.
// ============================================================================
module eabb_sine import eabb_pkg::*; #(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [ANGLE_WIDTH-2:0] phase,
    output logic [30:0]            sine
);

    localparam int QSHIFT = ANGLE_WIDTH - 2;
    localparam int PW     = ANGLE_WIDTH - 1 + 31;

    sine_st_t    st_reg [1:SINE_LAT-1];
    logic [30:0] sine_reg;
    logic [PW-1:0] w_prod;
    logic [31:0] fin;

    assign w_prod = PW'(phase) * PW'(HALF_PI_Q);
    assign fin    = mul_q({1'b0, st_reg[SINE_LAT-1].w}, ONE_Q - st_reg[SINE_LAT-1].acc[30:0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[1].w   <= w_prod[QSHIFT+30:QSHIFT];
            st_reg[1].w2  <= '0;
            st_reg[1].acc <= '0;
            st_reg[2].w   <= st_reg[1].w;
            st_reg[2].w2  <= mul_q({1'b0, st_reg[1].w}, st_reg[1].w);
            st_reg[2].acc <= '0;
            st_reg[3].w   <= st_reg[2].w;
            st_reg[3].w2  <= st_reg[2].w2;
            st_reg[3].acc <= div_const(st_reg[2].w2, 3'd0);
            // each Horner term: multiply by w2, then divide by the constant
            for (int i = 1; i < NUM_DIV; i++) begin
                st_reg[2*i+2].w   <= st_reg[2*i+1].w;
                st_reg[2*i+2].w2  <= st_reg[2*i+1].w2;
                st_reg[2*i+2].acc <= mul_q(st_reg[2*i+1].w2,
                                           ONE_Q - st_reg[2*i+1].acc[30:0]);
                st_reg[2*i+3].w   <= st_reg[2*i+2].w;
                st_reg[2*i+3].w2  <= st_reg[2*i+2].w2;
                st_reg[2*i+3].acc <= div_const(st_reg[2*i+2].acc, 3'(i));
            end
            sine_reg <= fin[30:0];
        end
    end

    assign sine = sine_reg;

endmodule

@@ hw/rtl/eabb_sqrt_cell.sv @@
// ============================================================================
// eabb_sqrt_cell
// One step of the bit-pair integer square root; cells chain into a pipeline.
// ============================================================================
module eabb_sqrt_cell import eabb_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic     aclk,
    input  logic     en,
    input  sqrt_st_t cell_in,
    output sqrt_st_t cell_out
);

    localparam logic [63:0] BIT_VAL = 64'd1 << (62 - 2 * STEP);

    logic [63:0] trial;
    logic        take;

    assign trial = cell_in.r + BIT_VAL;
    assign take  = {1'b0, cell_in.n} >= trial;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (take) begin
                cell_out.n <= cell_in.n - trial[62:0];
                cell_out.r <= (cell_in.r >> 1) + BIT_VAL;
            end else begin
                cell_out.n <= cell_in.n;
                cell_out.r <= cell_in.r >> 1;
            end
        end
    end

endmodule

@@ hw/rtl/eabb_div_cell.sv @@
// ============================================================================
// eabb_div_cell
// One restoring-division step: one quotient bit per cell.
// ============================================================================
module eabb_div_cell import eabb_pkg::*; (
    input  logic    aclk,
    input  logic    en,
    input  logic    num_bit,
    input  div_st_t cell_in,
    output div_st_t cell_out
);

    logic [32:0] trial;
    logic        ge;

    assign trial = {cell_in.rem, num_bit};
    assign ge    = trial >= {1'b0, cell_in.d};

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_out.rem <= ge ? 32'(trial - {1'b0, cell_in.d}) : trial[31:0];
            cell_out.d   <= cell_in.d;
            cell_out.q   <= {cell_in.q[29:0], ge};
        end
    end

endmodule

@@ hw/rtl/ellipse_arc_bounding_box.sv @@
// ============================================================================
// ellipse_arc_bounding_box
// Bounding box of an elliptical arc drawn in decreasing angle, y down.
// ============================================================================
// Input words carry the ellipse rectangle and the start and end binary angles.
// Each output word carries the arc's box; tuser flags a zero semi-axis, in
// which case both arc ends sit at the centre.
// The pipeline takes one word per clock while s_tready is high. An accepted word
// passes 12 stages of series sine, 4 stages of endpoint scaling, a chain of 32
// square-root cells and 31 divider cells, then 2 stages of placement and an
// output register before it shows on m_tvalid.
// A stall on m_tready is absorbed by a one-word skid stage behind the output
// register; s_tready drops only once both hold a word, and the whole pipeline
// freezes until the output drains.
// Reset clears all valid flags; data registers are not reset.
// ============================================================================
module ellipse_arc_bounding_box import eabb_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    localparam int S_TDATA_W = ((4 * COORD_WIDTH + 2 * ANGLE_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // rect_left, rect_top, rect_right, rect_bottom, start_angle, end_angle
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // box_left, box_top, box_right, box_bottom
    output logic [M_TDATA_W-1:0] m_tdata,
    // degenerate
    output logic [0:0]           m_tuser
);

    localparam int CW       = COORD_WIDTH;
    localparam int AW       = ANGLE_WIDTH;
    localparam int QSHIFT   = AW - 2;
    localparam int ST_SIN   = SINE_LAT;
    localparam int ST_MUL   = ST_SIN + 1;
    localparam int ST_NRM   = ST_MUL + 1;
    localparam int ST_SQ    = ST_NRM + 1;
    localparam int ST_SUM   = ST_SQ + 1;
    localparam int ST_ROOT  = ST_SUM + SQRT_STEPS;
    localparam int ST_QUO   = ST_ROOT + DIV_STEPS;
    localparam int ST_OFF   = ST_QUO + 1;
    localparam int LAT      = ST_OFF + 1;
    localparam logic [QSHIFT:0] QUARTER = (QSHIFT + 1)'(1) << QSHIFT;

    typedef struct packed {
        logic signed [CW-1:0] l;
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] r;
        logic signed [CW-1:0] b;
        logic [AW-1:0]        sa;
        logic [AW-1:0]        ea;
    } in_t;

    typedef struct packed {
        logic signed [CW-1:0] l;
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] r;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic [CW-1:0]        am;
        logic [CW-1:0]        bm;
        logic [1:0]           qd_s;
        logic [1:0]           qd_e;
        logic                 end_gt;
    } geom_t;

    typedef struct packed {
        logic signed [CW-1:0] box_bottom;
        logic signed [CW-1:0] box_right;
        logic signed [CW-1:0] box_top;
        logic signed [CW-1:0] box_left;
    } box_t;

    logic                 en;
    in_t                  in_reg;
    logic [LAT:0]         vld_reg;
    geom_t                geom_next;
    geom_t                geom_reg [1:LAT];
    logic signed [CW-1:0] px [2];
    logic signed [CW-1:0] py [2];
    logic [1:0]           quad [2];
    box_t                 box_next;
    logic                 deg_next;
    logic [15:0]          flags;
    box_t                 out_reg, skid_reg;
    logic                 out_deg_reg, skid_deg_reg;
    logic                 out_valid_reg, skid_valid_reg;

    function automatic logic signed [CW-1:0] place(input logic signed [CW-1:0] ctr,
                                                   input logic [62:0] off,
                                                   input logic neg);
        logic signed [64:0] base;
        logic signed [64:0] sum;
        logic [64:0]        mag;
        logic [34:0]        whole;
        base  = 65'(ctr) <<< FRAC;
        sum   = neg ? base - $signed({2'b00, off}) : base + $signed({2'b00, off});
        mag   = sum[64] ? 65'(-sum) : 65'(sum);
        whole = 35'(mag >> FRAC);
        return sum[64] ? CW'(-whole) : CW'(whole);
    endfunction

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------------------------------------------------------- input
    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg.l  <= s_tdata[CW-1:0];
            in_reg.t  <= s_tdata[2*CW-1:CW];
            in_reg.r  <= s_tdata[3*CW-1:2*CW];
            in_reg.b  <= s_tdata[4*CW-1:3*CW];
            in_reg.sa <= s_tdata[4*CW+AW-1:4*CW];
            in_reg.ea <= s_tdata[4*CW+2*AW-1:4*CW+AW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-1:0], s_tvalid};
        end
    end

    // centre and semi-axes, truncating toward zero
    always_comb begin
        logic signed [CW:0] sx, sy, dx, dy;
        logic [CW:0]        mx, my;
        sx = CW'(0) + {in_reg.l[CW-1], in_reg.l} + {in_reg.r[CW-1], in_reg.r};
        sy = {in_reg.t[CW-1], in_reg.t} + {in_reg.b[CW-1], in_reg.b};
        sx = sx + (CW + 1)'(sx[CW]);
        sy = sy + (CW + 1)'(sy[CW]);
        dx = {in_reg.r[CW-1], in_reg.r} - {in_reg.l[CW-1], in_reg.l};
        dy = {in_reg.b[CW-1], in_reg.b} - {in_reg.t[CW-1], in_reg.t};
        mx = dx[CW] ? (CW + 1)'(-dx) : (CW + 1)'(dx);
        my = dy[CW] ? (CW + 1)'(-dy) : (CW + 1)'(dy);
        geom_next.l      = in_reg.l;
        geom_next.t      = in_reg.t;
        geom_next.r      = in_reg.r;
        geom_next.b      = in_reg.b;
        geom_next.x0     = sx[CW:1];
        geom_next.y0     = sy[CW:1];
        geom_next.am     = mx[CW:1];
        geom_next.bm     = my[CW:1];
        geom_next.qd_s   = in_reg.sa[AW-1:AW-2];
        geom_next.qd_e   = in_reg.ea[AW-1:AW-2];
        geom_next.end_gt = in_reg.ea > in_reg.sa;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geom_reg[1] <= geom_next;
            for (int k = 2; k <= LAT; k++) begin
                geom_reg[k] <= geom_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------- arc endpoints
    for (genvar e = 0; e < 2; e++) begin : g_end
        logic [AW-1:0]   ang;
        logic [QSHIFT:0] ph_lo, ph_hi;
        logic [30:0]     sin_lo, sin_hi;
        logic [1:0]      qd;
        logic [30:0]     c_val, s_val;
        logic            c_neg, s_neg;
        ep_t             ep_next;
        ep_t             ep_reg [ST_MUL:LAT];
        logic [62:0]     u_reg, v_reg;
        logic [30:0]     un_next, vn_next;
        logic [30:0]     un_reg [ST_NRM:ST_ROOT];
        logic [30:0]     vn_reg [ST_NRM:ST_ROOT];
        logic [61:0]     uu_reg, vv_reg;
        logic [62:0]     n_reg;
        sqrt_st_t        sq_link [0:SQRT_STEPS];
        div_st_t         dx_link [0:DIV_STEPS];
        div_st_t         dy_link [0:DIV_STEPS];
        logic            dz_reg [ST_ROOT+1:ST_OFF];
        logic [62:0]     offx_reg, offy_reg;
        logic signed [CW-1:0] px_reg, py_reg;
        logic            deg_off;

        assign ang   = (e == 0) ? in_reg.sa : in_reg.ea;
        assign ph_lo = (QSHIFT + 1)'(ang[QSHIFT-1:0]);
        assign ph_hi = QUARTER - ph_lo;

        eabb_sine #(.ANGLE_WIDTH(AW)) u_sin_lo (
            .aclk  (aclk),
            .en    (en),
            .phase (ph_lo),
            .sine  (sin_lo)
        );

        eabb_sine #(.ANGLE_WIDTH(AW)) u_sin_hi (
            .aclk  (aclk),
            .en    (en),
            .phase (ph_hi),
            .sine  (sin_hi)
        );

        assign qd = (e == 0) ? geom_reg[ST_SIN].qd_s : geom_reg[ST_SIN].qd_e;

        always_comb begin
            unique case (qd)
                QUAD_1: begin
                    c_val = sin_hi; c_neg = 1'b0; s_val = sin_lo; s_neg = 1'b0;
                end
                QUAD_2: begin
                    c_val = sin_lo; c_neg = 1'b1; s_val = sin_hi; s_neg = 1'b0;
                end
                QUAD_3: begin
                    c_val = sin_hi; c_neg = 1'b1; s_val = sin_lo; s_neg = 1'b1;
                end
                default: begin
                    c_val = sin_lo; c_neg = 1'b0; s_val = sin_hi; s_neg = 1'b1;
                end
            endcase
            // an exact zero counts as non-negative
            ep_next.cneg = c_neg && (c_val != '0);
            ep_next.sneg = s_neg && (s_val != '0);
            ep_next.quad = ep_next.cneg ? (ep_next.sneg ? QUAD_3 : QUAD_2)
                                        : (ep_next.sneg ? QUAD_4 : QUAD_1);
        end

        // scale back below 2^31 so the squares fit
        always_comb begin
            logic [62:0] o;
            logic [5:0]  sh;
            o  = u_reg | v_reg;
            sh = '0;
            for (int i = 31; i < 63; i++) begin
                if (o[i]) begin
                    sh = 6'(i - 30);
                end
            end
            un_next = 31'(u_reg >> sh);
            vn_next = 31'(v_reg >> sh);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ep_reg[ST_MUL] <= ep_next;
                for (int k = ST_MUL + 1; k <= LAT; k++) begin
                    ep_reg[k] <= ep_reg[k-1];
                end
                u_reg <= 63'(geom_reg[ST_SIN].bm) * 63'(c_val);
                v_reg <= 63'(geom_reg[ST_SIN].am) * 63'(s_val);
                un_reg[ST_NRM] <= un_next;
                vn_reg[ST_NRM] <= vn_next;
                for (int k = ST_NRM + 1; k <= ST_ROOT; k++) begin
                    un_reg[k] <= un_reg[k-1];
                    vn_reg[k] <= vn_reg[k-1];
                end
                uu_reg <= 62'(un_reg[ST_NRM]) * 62'(un_reg[ST_NRM]);
                vv_reg <= 62'(vn_reg[ST_NRM]) * 62'(vn_reg[ST_NRM]);
                n_reg  <= 63'(uu_reg) + 63'(vv_reg);
                dz_reg[ST_ROOT+1] <= sq_link[SQRT_STEPS].r[31:0] == '0;
                for (int k = ST_ROOT + 2; k <= ST_OFF; k++) begin
                    dz_reg[k] <= dz_reg[k-1];
                end
                offx_reg <= 63'(geom_reg[ST_QUO].am) * 63'(dx_link[DIV_STEPS].q);
                offy_reg <= 63'(geom_reg[ST_QUO].bm) * 63'(dy_link[DIV_STEPS].q);
                if (deg_off) begin
                    px_reg <= geom_reg[ST_OFF].x0;
                    py_reg <= geom_reg[ST_OFF].y0;
                end else begin
                    px_reg <= place(geom_reg[ST_OFF].x0, offx_reg, ep_reg[ST_OFF].cneg);
                    py_reg <= place(geom_reg[ST_OFF].y0, offy_reg, ep_reg[ST_OFF].sneg);
                end
            end
        end

        assign deg_off = geom_reg[ST_OFF].am == '0 || geom_reg[ST_OFF].bm == '0
                         || dz_reg[ST_OFF];

        // square root of u^2 + v^2
        assign sq_link[0] = '{n: n_reg, r: '0};
        for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
            eabb_sqrt_cell #(.STEP(k)) u_cell (
                .aclk     (aclk),
                .en       (en),
                .cell_in  (sq_link[k]),
                .cell_out (sq_link[k+1])
            );
        end

        // (u << 30) / d and (v << 30) / d; the upper quotient bits are known
        // zero, so the remainder starts at u >> 1
        assign dx_link[0] = '{rem: 32'(un_reg[ST_ROOT] >> 1),
                              d: sq_link[SQRT_STEPS].r[31:0], q: '0};
        assign dy_link[0] = '{rem: 32'(vn_reg[ST_ROOT] >> 1),
                              d: sq_link[SQRT_STEPS].r[31:0], q: '0};
        for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
            eabb_div_cell u_cell_x (
                .aclk     (aclk),
                .en       (en),
                .num_bit  ((k == 0) ? un_reg[ST_ROOT][0] : 1'b0),
                .cell_in  (dx_link[k]),
                .cell_out (dx_link[k+1])
            );
            eabb_div_cell u_cell_y (
                .aclk     (aclk),
                .en       (en),
                .num_bit  ((k == 0) ? vn_reg[ST_ROOT][0] : 1'b0),
                .cell_in  (dy_link[k]),
                .cell_out (dy_link[k+1])
            );
        end

        assign px[e]   = px_reg;
        assign py[e]   = py_reg;
        assign quad[e] = ep_reg[LAT].quad;
    end

    // ------------------------------------------------------------ box sides
    always_comb begin
        flags = SIDE_TABLE[{quad[0], quad[1]}];
        if (quad[0] == quad[1] && geom_reg[LAT].end_gt) begin
            flags = SIDE_ALL;
        end
        box_next.box_left   = ((flags & SIDE_LEFT) != '0) ? geom_reg[LAT].l
                              : ((px[0] < px[1]) ? px[0] : px[1]);
        box_next.box_top    = ((flags & SIDE_TOP) != '0) ? geom_reg[LAT].t
                              : ((py[0] < py[1]) ? py[0] : py[1]);
        box_next.box_right  = ((flags & SIDE_RIGHT) != '0) ? geom_reg[LAT].r
                              : ((px[0] > px[1]) ? px[0] : px[1]);
        box_next.box_bottom = ((flags & SIDE_BOTTOM) != '0) ? geom_reg[LAT].b
                              : ((py[0] > py[1]) ? py[0] : py[1]);
        deg_next = geom_reg[LAT].am == '0 || geom_reg[LAT].bm == '0;
    end

    // ------------------------------------------------- output and skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg || (en && vld_reg[LAT]);
            skid_valid_reg <= 1'b0;
        end else if (en && vld_reg[LAT]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg     <= skid_valid_reg ? skid_reg : box_next;
            out_deg_reg <= skid_valid_reg ? skid_deg_reg : deg_next;
        end else if (en) begin
            skid_reg     <= box_next;
            skid_deg_reg <= deg_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);
    assign m_tuser  = out_deg_reg;

    // ----------------------------------------------------------- assertions
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[LAT] && en && out_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("finished word dropped during output stall");

endmodule
